// ===== hdl/npcs_pkg.sv =====
// shared types and constants for the nearest palette color search
`timescale 1ns / 1ps

package npcs_pkg;

    localparam int PALETTE_DEPTH = 64;
    localparam int ADDR_W        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);

    localparam int CHAN_W        = 8;
    localparam int COLOR_W       = 3 * CHAN_W;
    localparam int SQ_W          = 2 * CHAN_W;
    localparam int DIST_W        = 18;
    localparam int COUNT_W       = 7;
    localparam int SLOT_W        = 6;
    localparam int CFG_DATA_W    = 18;
    localparam int CFG_IDX_W     = 1;

    localparam logic [DIST_W-1:0] LIMIT_RESET = DIST_W'(200000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PALETTE_COUNT  = 1'b0,
        CFG_DISTANCE_LIMIT = 1'b1
    } npcs_cfg_reg_t;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_QUERY = 1'b1
    } npcs_kind_t;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] entry_index;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } npcs_in_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] match_index;
        logic [CHAN_W-1:0] match_red;
        logic [CHAN_W-1:0] match_green;
        logic [CHAN_W-1:0] match_blue;
    } npcs_out_t;

    typedef struct packed {
        logic [SQ_W-1:0]    sq_red;
        logic [SQ_W-1:0]    sq_green;
        logic [SQ_W-1:0]    sq_blue;
        logic [COLOR_W-1:0] color;
    } npcs_dist_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } npcs_state_t;

endpackage

// ===== hdl/npcs_palette_mem.sv =====
// palette storage, one write port and one registered read port
`timescale 1ns / 1ps

module npcs_palette_mem
    import npcs_pkg::*;
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [COLOR_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [COLOR_W-1:0] rd_data
);

    logic [COLOR_W-1:0] mem [PALETTE_DEPTH];
    logic [COLOR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/npcs_dist_unit.sv =====
// shared distance unit: per-channel squared differences, registered
`timescale 1ns / 1ps

module npcs_dist_unit
    import npcs_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [COLOR_W-1:0] query_color,
    input  logic [COLOR_W-1:0] entry_color,
    output npcs_dist_t         sq_out
);

    npcs_dist_t dist_reg;
    npcs_dist_t dist_next;

    function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
        logic [CHAN_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

    always_comb
    begin
        dist_next.sq_red   = sq_diff(entry_color[3*CHAN_W-1:2*CHAN_W],
                                     query_color[3*CHAN_W-1:2*CHAN_W]);
        dist_next.sq_green = sq_diff(entry_color[2*CHAN_W-1:CHAN_W],
                                     query_color[2*CHAN_W-1:CHAN_W]);
        dist_next.sq_blue  = sq_diff(entry_color[CHAN_W-1:0],
                                     query_color[CHAN_W-1:0]);
        dist_next.color    = entry_color;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg <= dist_next;
        end
    end

    assign sq_out = dist_reg;

endmodule

// ===== hdl/nearest_palette_color_search.sv =====
// top level: configuration, scan sequencer, best-match tracking, result register
`timescale 1ns / 1ps

// A write item stores one palette entry. A query item scans entries
// 0 .. min(palette_count, 64) - 1 through one shared distance unit, one
// entry per cycle, behind a registered memory read and the registered
// squares; an exact match ends the scan early. The block takes no new item
// while a query runs; the result is held in an output register, and a
// finished query waits in the done state only if the previous result has
// not been taken. Entries must be written before a query reaches them.

module nearest_palette_color_search
    import npcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  npcs_in_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output npcs_out_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    npcs_state_t        state_reg, state_next;
    logic [COUNT_W-1:0] palette_count_reg;
    logic [DIST_W-1:0]  distance_limit_reg;

    logic [COLOR_W-1:0] query_reg, query_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic [DIST_W-1:0]  best_reg, best_next;
    logic               found_reg, found_next;
    logic [ADDR_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [COLOR_W-1:0] hit_color_reg, hit_color_next;
    logic               v_rd_reg, v_rd_next;
    logic [ADDR_W-1:0]  idx_rd_reg, idx_rd_next;
    logic               v_sq_reg, v_sq_next;
    logic [ADDR_W-1:0]  idx_sq_reg, idx_sq_next;
    logic               out_valid_reg, out_valid_next;
    npcs_out_t          out_data_reg, out_data_next;

    logic               in_fire;
    logic               wr_en;
    logic               rd_en;
    logic [COLOR_W-1:0] rd_data;
    npcs_dist_t         sq_terms;
    logic [DIST_W-1:0]  dist_sum;
    logic [CNT_W-1:0]   count_eff;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign wr_en = in_fire && (in_data.kind == KIND_WRITE)
                   && (int'(in_data.entry_index) < PALETTE_DEPTH);
    assign rd_en = (state_reg == ST_SCAN) && (issue_reg < count_reg);

    assign count_eff = (int'(palette_count_reg) > PALETTE_DEPTH)
                       ? CNT_W'(PALETTE_DEPTH) : CNT_W'(palette_count_reg);

    assign dist_sum = DIST_W'(sq_terms.sq_red) + DIST_W'(sq_terms.sq_green)
                      + DIST_W'(sq_terms.sq_blue);

    npcs_palette_mem u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(in_data.entry_index)),
        .wr_data ({in_data.red, in_data.green, in_data.blue}),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    npcs_dist_unit u_dist (
        .clk         (clk),
        .en          (v_rd_reg),
        .query_color (query_reg),
        .entry_color (rd_data),
        .sq_out      (sq_terms)
    );

    always_comb
    begin
        state_next     = state_reg;
        query_next     = query_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        best_next      = best_reg;
        found_next     = found_reg;
        hit_idx_next   = hit_idx_reg;
        hit_color_next = hit_color_reg;
        v_rd_next      = 1'b0;
        idx_rd_next    = idx_rd_reg;
        v_sq_next      = 1'b0;
        idx_sq_next    = idx_sq_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (in_data.kind == KIND_QUERY))
                begin
                    query_next     = {in_data.red, in_data.green, in_data.blue};
                    count_next     = count_eff;
                    issue_next     = '0;
                    best_next      = distance_limit_reg;
                    found_next     = 1'b0;
                    hit_idx_next   = '0;
                    hit_color_next = '0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                v_rd_next   = rd_en;
                idx_rd_next = issue_reg[ADDR_W-1:0];
                if (rd_en)
                begin
                    issue_next = issue_reg + 1'b1;
                end
                v_sq_next   = v_rd_reg;
                idx_sq_next = idx_rd_reg;
                if (!rd_en && !v_rd_reg && !v_sq_reg)
                begin
                    state_next = ST_DONE;
                end
                if (v_sq_reg)
                begin
                    priority if (dist_sum == '0)
                    begin
                        found_next     = 1'b1;
                        hit_idx_next   = idx_sq_reg;
                        hit_color_next = sq_terms.color;
                        v_rd_next      = 1'b0;
                        v_sq_next      = 1'b0;
                        state_next     = ST_DONE;
                    end
                    else if (dist_sum < best_reg)
                    begin
                        best_next      = dist_sum;
                        found_next     = 1'b1;
                        hit_idx_next   = idx_sq_reg;
                        hit_color_next = sq_terms.color;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.found       = found_reg;
                    out_data_next.match_index = found_reg ? SLOT_W'(hit_idx_reg) : '0;
                    out_data_next.match_red   = found_reg
                        ? hit_color_reg[3*CHAN_W-1:2*CHAN_W] : '0;
                    out_data_next.match_green = found_reg
                        ? hit_color_reg[2*CHAN_W-1:CHAN_W] : '0;
                    out_data_next.match_blue  = found_reg
                        ? hit_color_reg[CHAN_W-1:0] : '0;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            palette_count_reg  <= '0;
            distance_limit_reg <= LIMIT_RESET;
            issue_reg          <= '0;
            count_reg          <= '0;
            v_rd_reg           <= 1'b0;
            v_sq_reg           <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            count_reg     <= count_next;
            v_rd_reg      <= v_rd_next;
            v_sq_reg      <= v_sq_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_PALETTE_COUNT:  palette_count_reg  <= cfg_data[COUNT_W-1:0];
                    CFG_DISTANCE_LIMIT: distance_limit_reg <= cfg_data[DIST_W-1:0];
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        query_reg     <= query_next;
        best_reg      <= best_next;
        found_reg     <= found_next;
        hit_idx_reg   <= hit_idx_next;
        hit_color_reg <= hit_color_next;
        idx_rd_reg    <= idx_rd_next;
        idx_sq_reg    <= idx_sq_next;
        out_data_reg  <= out_data_next;
    end

endmodule
